@@ rtl/core/usc_pkg.sv @@
package usc_pkg;

  typedef logic [7:0] char_t;

  localparam int NUM_SCHEMES = 18;
  localparam int MAX_SCHEME  = 8;

  // Parse phase codes
  localparam logic [2:0] PH_SCHEME      = 3'd0;
  localparam logic [2:0] PH_COLON       = 3'd1;
  localparam logic [2:0] PH_COLON_SLASH = 3'd2;
  localparam logic [2:0] PH_AUTHORITY   = 3'd3;
  localparam logic [2:0] PH_REST        = 3'd4;
  localparam logic [2:0] PH_DEAD        = 3'd5;

  localparam char_t CH_COLON = 8'h3A;
  localparam char_t CH_SLASH = 8'h2F;
  localparam char_t CH_QUERY = 8'h3F;
  localparam char_t CH_HASH  = 8'h23;
  localparam char_t CH_AT    = 8'h40;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_NUL   = 8'h00;

  typedef logic [NUM_SCHEMES-1:0] cand_mask_t;

  // Stream scheme names, lower case, padded with NUL
  localparam char_t SCHEME_TBL [NUM_SCHEMES][MAX_SCHEME] = '{
    '{"f", "t", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"h", "t", "t", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"h", "t", "t", "p", "s", CH_NUL, CH_NUL, CH_NUL},
    '{"m", "m", "s", "h", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"m", "m", "s", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"r", "t", "m", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"r", "t", "m", "p", "e", CH_NUL, CH_NUL, CH_NUL},
    '{"r", "t", "m", "p", "s", CH_NUL, CH_NUL, CH_NUL},
    '{"r", "t", "m", "p", "t", CH_NUL, CH_NUL, CH_NUL},
    '{"r", "t", "m", "p", "t", "e", CH_NUL, CH_NUL},
    '{"r", "t", "m", "p", "t", "s", CH_NUL, CH_NUL},
    '{"r", "t", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"r", "t", "s", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"s", "c", "t", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"s", "r", "t", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"t", "c", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"u", "d", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"u", "d", "p", "l", "i", "t", "e", CH_NUL}
  };

  localparam logic [3:0] SCHEME_LEN [NUM_SCHEMES] = '{
    4'd3, 4'd4, 4'd5, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5,
    4'd6, 4'd6, 4'd3, 4'd4, 4'd4, 4'd4, 4'd3, 4'd3, 4'd7
  };

  function automatic logic is_letter(input char_t c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_scheme_byte(input char_t c);
    return is_letter(c) || ((c >= "0") && (c <= "9")) ||
           (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_DOT);
  endfunction

  function automatic char_t to_lower(input char_t c);
    return ((c >= "A") && (c <= "Z")) ? char_t'(c + 8'd32) : c;
  endfunction

endpackage

@@ rtl/core/usc_in_if.sv @@
interface usc_in_if import usc_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_in;
  logic  last_char;

  modport source(output valid, char_in, last_char, input ready);
  modport sink(input valid, char_in, last_char, output ready);
endinterface

@@ rtl/core/usc_out_if.sv @@
interface usc_out_if;
  logic valid;
  logic ready;
  logic is_network;
  logic is_supported;
  logic has_credentials;
  logic has_sensitive;

  modport source(output valid, is_network, is_supported, has_credentials, has_sensitive,
                 input ready);
  modport sink(input valid, is_network, is_supported, has_credentials, has_sensitive,
               output ready);
endinterface

@@ rtl/core/uri_scheme_classifier.sv @@
// A verdict passes from the byte register into the result register, which offers it after the last byte.
// Throughput: one byte per clock unless a verdict waits to be taken; the parse state updates once per byte in one pass.
// Backpressure: the byte register holds only while a verdict waits to be taken.
// Reset: rst_n synchronous, active low; clears both valid flags and returns the
// parser to the scheme phase with a full candidate mask.
module uri_scheme_classifier import usc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  usc_in_if.sink    in_ch,
  usc_out_if.source out_ch
);

  // Byte register
  logic  s1_valid_r;
  char_t s1_char_r;
  logic  s1_last_r;

  // Parse state
  logic [2:0] phase_r,  phase_nxt;
  logic [3:0] len_r,    len_nxt;
  cand_mask_t mask_r,   mask_nxt;
  logic       cred_r,   cred_nxt;
  logic       qf_r,     qf_nxt;

  // Result register
  logic out_valid_r;
  logic net_r, sup_r, cred_out_r, sens_r;

  cand_mask_t keep;
  cand_mask_t len_hit;
  char_t      lc;
  logic       s1_drain;
  logic       s1_adv;
  logic       net_nxt;
  logic       sup_nxt;

  // A byte that is not last never produces a verdict, so it can always advance.
  assign s1_drain    = !s1_last_r || !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && s1_drain;
  assign in_ch.ready = !s1_valid_r || s1_drain;

  assign lc = to_lower(s1_char_r);

  // Per-scheme lanes: keep a candidate whose byte at this position matches
  always_comb begin
    for (int i = 0; i < NUM_SCHEMES; i++) begin
      keep[i] = (len_r < SCHEME_LEN[i]) && !len_r[3] &&
                (SCHEME_TBL[i][len_r[2:0]] == lc);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    mask_nxt  = mask_r;
    cred_nxt  = cred_r;
    qf_nxt    = qf_r;
    case (phase_r)
      PH_SCHEME: begin
        if ((s1_char_r == CH_COLON) && (len_r != 4'd0)) begin
          phase_nxt = PH_COLON;
        end else if ((len_r == 4'd0) ? is_letter(s1_char_r)
                                     : is_scheme_byte(s1_char_r)) begin
          mask_nxt = mask_r & keep;
          // saturate so an over-long scheme never wraps back onto a match
          if (len_r != 4'd15) begin
            len_nxt = len_r + 4'd1;
          end
        end else begin
          phase_nxt = PH_DEAD;
        end
      end
      PH_COLON: begin
        phase_nxt = (s1_char_r == CH_SLASH) ? PH_COLON_SLASH : PH_DEAD;
      end
      PH_COLON_SLASH: begin
        phase_nxt = (s1_char_r == CH_SLASH) ? PH_AUTHORITY : PH_DEAD;
      end
      PH_AUTHORITY: begin
        if (s1_char_r == CH_AT) begin
          cred_nxt = 1'b1;
        end
        if ((s1_char_r == CH_SLASH) || (s1_char_r == CH_QUERY) ||
            (s1_char_r == CH_HASH)) begin
          phase_nxt = PH_REST;
        end
        if ((s1_char_r == CH_QUERY) || (s1_char_r == CH_HASH)) begin
          qf_nxt = 1'b1;
        end
      end
      PH_REST: begin
        if ((s1_char_r == CH_QUERY) || (s1_char_r == CH_HASH)) begin
          qf_nxt = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_DEAD;
      end
    endcase
  end

  // Verdict from the state as it stands after the last byte
  always_comb begin
    for (int i = 0; i < NUM_SCHEMES; i++) begin
      len_hit[i] = (SCHEME_LEN[i] == len_nxt);
    end
  end

  assign net_nxt = (phase_nxt == PH_AUTHORITY) || (phase_nxt == PH_REST);
  assign sup_nxt = net_nxt && |(mask_nxt & len_hit);

  // Byte register: load on every transfer, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.char_in;
      s1_last_r <= in_ch.last_char;
    end
  end

  // Parse state: advance per byte, return to reset after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SCHEME;
      len_r   <= 4'd0;
      mask_r  <= '1;
      cred_r  <= 1'b0;
      qf_r    <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        phase_r <= PH_SCHEME;
        len_r   <= 4'd0;
        mask_r  <= '1;
        cred_r  <= 1'b0;
        qf_r    <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        len_r   <= len_nxt;
        mask_r  <= mask_nxt;
        cred_r  <= cred_nxt;
        qf_r    <= qf_nxt;
      end
    end
  end

  // Result register: hold the verdict until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv && s1_last_r) begin
      net_r      <= net_nxt;
      sup_r      <= sup_nxt;
      cred_out_r <= net_nxt && cred_nxt;
      sens_r     <= net_nxt && (cred_nxt || qf_nxt);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.is_network      = net_r;
  assign out_ch.is_supported    = sup_r;
  assign out_ch.has_credentials = cred_out_r;
  assign out_ch.has_sensitive   = sens_r;

  a_verdict_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("verdict raised without a last byte");

  a_sup_needs_net : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!sup_r || net_r))
    else $error("supported verdict on a non-network URI");

  a_cred_is_sensitive : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!cred_out_r || sens_r))
    else $error("credentials without sensitive flag");

  a_state_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(s1_adv && s1_last_r)) |->
      ((phase_r == PH_SCHEME) && (len_r == 4'd0) && (mask_r == '1) && !cred_r && !qf_r))
    else $error("parse state not cleared after last byte");

  a_mask_full_at_start : assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_SCHEME) && (len_r == 4'd0)) |-> (mask_r == '1))
    else $error("candidate mask narrowed before any scheme byte");

endmodule
